>>> rtl/plr_pkg.sv
// ----------------------------------------------------------------------------
// plr_pkg: shared widths and codes for the pseudorange linearization row
// Register addresses, field widths, pipeline depth and the sideband struct.
// ----------------------------------------------------------------------------
package plr_pkg;

    localparam int COORD_W  = 37;
    localparam int DIFF_W   = 38;
    localparam int MAG_W    = 38;
    localparam int SQ_W     = 76;
    localparam int SUM_W    = 80;
    localparam int ROOT_W   = 40;
    localparam int GEO_W    = 38;
    localparam int DIR_W    = 32;
    localparam int MIS_W    = 41;
    localparam int DT_W     = 38;
    localparam int CLK_W    = 37;
    localparam int QUO_W    = 31;
    localparam int NUM_W    = 68;

    localparam logic [63:0] LIGHT_SPEED = 64'd299792458;

    // Register byte offsets.
    localparam logic [4:0] ADDR_STATION_X = 5'd0;
    localparam logic [4:0] ADDR_STATION_Y = 5'd8;
    localparam logic [4:0] ADDR_STATION_Z = 5'd16;
    localparam logic [4:0] ADDR_RX_CLOCK  = 5'd24;

    // Pipeline: 1 setup + 2 square + 40 root + 1 round + 68 divide + 1 finish.
    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = NUM_W;

    typedef struct packed {
        logic [DIFF_W-1:0] dx;
        logic [DIFF_W-1:0] dy;
        logic [DIFF_W-1:0] dz;
        logic signed [MIS_W+2:0] rest;
    } plr_side_t;

endpackage

>>> rtl/pseudorange_linearization_row_top.sv
// ----------------------------------------------------------------------------
// pseudorange_linearization_row_top
// One satellite observation in, one linearization row out, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: the s_ channel takes one observation per transfer (satellite
// position, clock bias, tropospheric delay, pseudorange). The m_ channel
// gives the geometric range, the three direction cosines in Q2.30, the
// saturated misclosure and the zero-range flag. Station position and
// receiver clock bias are to be written over the APB port while the block
// is idle; the block itself does not enforce this. Throughput is one
// observation per cycle unless the output stalls. There are 113 register
// stages: one for differences, two for the squares (partial products, then
// their sum), 40 for the bit-serial square root (one result bit per stage),
// one to round, 68 for the restoring divider that forms the directions (one
// quotient bit per stage, the three axes in parallel lanes) and one for
// rounding, clamping and saturation. Reset clears all valid bits and the
// configuration registers. When the last stage holds a result that has not
// been taken, the whole pipeline holds, bubbles included, and s_ready is
// low in that same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pseudorange_linearization_row_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [36:0]          s_sat_x,
    input  logic signed [36:0]          s_sat_y,
    input  logic signed [36:0]          s_sat_z,
    input  logic signed [30:0]          s_sat_clock_bias,
    input  logic [19:0]                 s_trop_delay,
    input  logic [35:0]                 s_pseudorange,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [37:0]                 m_geo_range,
    output logic signed [31:0]          m_dir_x,
    output logic signed [31:0]          m_dir_y,
    output logic signed [31:0]          m_dir_z,
    output logic signed [40:0]          m_misclosure,
    output logic                        m_zero_range
);

    localparam int NR = plr_pkg::ROOT_STEPS;
    localparam int ND = plr_pkg::DIV_STEPS;
    localparam int DW = plr_pkg::DIFF_W;
    localparam int SW = plr_pkg::SUM_W;
    localparam int RW = plr_pkg::ROOT_W;
    localparam int NW = plr_pkg::NUM_W;
    localparam int RSTAGES = 4 + NR + ND;
    localparam int TOTAL   = RSTAGES + 1;

    logic signed [36:0] station_x_reg, station_y_reg, station_z_reg, rx_clock_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_x_reg <= '0;
            station_y_reg <= '0;
            station_z_reg <= '0;
            rx_clock_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                plr_pkg::ADDR_STATION_X: station_x_reg <= pwdata[36:0];
                plr_pkg::ADDR_STATION_Y: station_y_reg <= pwdata[36:0];
                plr_pkg::ADDR_STATION_Z: station_z_reg <= pwdata[36:0];
                plr_pkg::ADDR_RX_CLOCK:  rx_clock_reg  <= pwdata[36:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            plr_pkg::ADDR_STATION_X: prdata = {{27{station_x_reg[36]}}, station_x_reg};
            plr_pkg::ADDR_STATION_Y: prdata = {{27{station_y_reg[36]}}, station_y_reg};
            plr_pkg::ADDR_STATION_Z: prdata = {{27{station_z_reg[36]}}, station_z_reg};
            plr_pkg::ADDR_RX_CLOCK:  prdata = {{27{rx_clock_reg[36]}}, rx_clock_reg};
            default:                 prdata = '0;
        endcase
    end

    // Global stall: every stage advances together unless the output holds.
    logic vld_reg [TOTAL];
    logic adv;
    assign adv     = !vld_reg[TOTAL-1] || m_ready;
    assign s_ready = adv;

    // Stage 0: differences and clock product operands.
    plr_pkg::plr_side_t side_reg [RSTAGES];
    logic signed [DW-1:0] dx0, dy0, dz0, dt0;
    logic [DW-1:0] mx_reg, my_reg, mz_reg, mdt_reg;
    logic dtneg_reg;

    assign dx0 = DW'(station_x_reg) - DW'(s_sat_x);
    assign dy0 = DW'(station_y_reg) - DW'(s_sat_y);
    assign dz0 = DW'(station_z_reg) - DW'(s_sat_z);
    assign dt0 = DW'(rx_clock_reg) - DW'(s_sat_clock_bias);

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0].dx   <= dx0;
            side_reg[0].dy   <= dy0;
            side_reg[0].dz   <= dz0;
            side_reg[0].rest <= $signed({24'd0, s_trop_delay}) - $signed({8'd0, s_pseudorange});
            mx_reg  <= dx0[DW-1] ? DW'(-dx0) : dx0;
            my_reg  <= dy0[DW-1] ? DW'(-dy0) : dy0;
            mz_reg  <= dz0[DW-1] ? DW'(-dz0) : dz0;
            mdt_reg <= dt0[DW-1] ? DW'(-dt0) : dt0;
            dtneg_reg <= dt0[DW-1];
        end
    end

    // Stage 1: partial products of the squares, each magnitude split into two
    // 19-bit halves, and the clock product. |dt| < 2^37 and c < 2^29, so the
    // product needs 66 bits.
    logic [37:0] hh_reg [3];
    logic [37:0] hl_reg [3];
    logic [37:0] ll_reg [3];
    logic [66:0] cprod;
    logic [36:0] cm_reg;
    logic dtneg1_reg;

    assign cprod = 67'(mdt_reg) * 67'(plr_pkg::LIGHT_SPEED) + 67'd536870912;

    always_ff @(posedge aclk) begin
        if (adv) begin
            hh_reg[0] <= 38'(mx_reg[37:19]) * 38'(mx_reg[37:19]);
            hl_reg[0] <= 38'(mx_reg[37:19]) * 38'(mx_reg[18:0]);
            ll_reg[0] <= 38'(mx_reg[18:0]) * 38'(mx_reg[18:0]);
            hh_reg[1] <= 38'(my_reg[37:19]) * 38'(my_reg[37:19]);
            hl_reg[1] <= 38'(my_reg[37:19]) * 38'(my_reg[18:0]);
            ll_reg[1] <= 38'(my_reg[18:0]) * 38'(my_reg[18:0]);
            hh_reg[2] <= 38'(mz_reg[37:19]) * 38'(mz_reg[37:19]);
            hl_reg[2] <= 38'(mz_reg[37:19]) * 38'(mz_reg[18:0]);
            ll_reg[2] <= 38'(mz_reg[18:0]) * 38'(mz_reg[18:0]);
            cm_reg     <= cprod[66:30];
            dtneg1_reg <= dtneg_reg;
            side_reg[1] <= side_reg[0];
        end
    end

    // Stage 2: sum of squares and the clock term. The high and low squares
    // of one axis do not overlap, so they join by concatenation.
    logic [SW-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= SW'({hh_reg[0], ll_reg[0]}) + SW'({hl_reg[0], 20'd0})
                       + SW'({hh_reg[1], ll_reg[1]}) + SW'({hl_reg[1], 20'd0})
                       + SW'({hh_reg[2], ll_reg[2]}) + SW'({hl_reg[2], 20'd0});
            side_reg[2].dx   <= side_reg[1].dx;
            side_reg[2].dy   <= side_reg[1].dy;
            side_reg[2].dz   <= side_reg[1].dz;
            side_reg[2].rest <= side_reg[1].rest
                                + (dtneg1_reg ? -$signed({7'd0, cm_reg})
                                              : $signed({7'd0, cm_reg}));
        end
    end

    // Square root: one bit per stage, restoring digit recurrence.
    logic [SW-1:0]  rad_reg [NR+1];
    logic [RW+1:0]  rem_reg [NR+1];
    logic [RW-1:0]  root_reg [NR+1];

    assign rad_reg[0]  = sum_reg;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;

    for (genvar k = 0; k < NR; k++) begin : g_root
        logic [RW+1:0] trial, shifted;
        logic [RW+1:0] rem_n_reg;
        logic [RW-1:0] root_n_reg;
        logic [SW-1:0] rad_n_reg;
        assign shifted = {rem_reg[k][RW-1:0], rad_reg[k][SW-1 -: 2]};
        assign trial   = shifted - {root_reg[k], 2'b01};
        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_n_reg <= {rad_reg[k][SW-3:0], 2'b00};
                if (!trial[RW+1]) begin
                    rem_n_reg  <= trial;
                    root_n_reg <= {root_reg[k][RW-2:0], 1'b1};
                end else begin
                    rem_n_reg  <= shifted;
                    root_n_reg <= {root_reg[k][RW-2:0], 1'b0};
                end
                side_reg[k+3] <= side_reg[k+2];
            end
        end
        assign rad_reg[k+1]  = rad_n_reg;
        assign rem_reg[k+1]  = rem_n_reg;
        assign root_reg[k+1] = root_n_reg;
    end

    // Round: remainder s - q^2 > q means round up. Remainder stays < 2q+1.
    logic [RW:0] r_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg <= {1'b0, root_reg[NR]}
                     + {{RW{1'b0}}, (rem_reg[NR] > {2'b00, root_reg[NR]})};
            side_reg[NR+3] <= side_reg[NR+2];
        end
    end

    // Divider: three lanes of restoring division, one quotient bit per stage.
    logic [NW-1:0] num_reg [3][ND+1];
    logic [RW+1:0] drem_reg [3][ND+1];
    logic [NW-1:0] quo_reg [3][ND+1];
    logic [RW:0]   dr_reg [ND+1];

    assign num_reg[0][0] = {side_reg[NR+3].dx[DW-1] ? DW'(-side_reg[NR+3].dx)
                                                    : side_reg[NR+3].dx, 30'd0};
    assign num_reg[1][0] = {side_reg[NR+3].dy[DW-1] ? DW'(-side_reg[NR+3].dy)
                                                    : side_reg[NR+3].dy, 30'd0};
    assign num_reg[2][0] = {side_reg[NR+3].dz[DW-1] ? DW'(-side_reg[NR+3].dz)
                                                    : side_reg[NR+3].dz, 30'd0};
    assign dr_reg[0] = r_reg;

    for (genvar a = 0; a < 3; a++) begin : g_seed
        assign drem_reg[a][0] = '0;
        assign quo_reg[a][0]  = '0;
    end

    for (genvar k = 0; k < ND; k++) begin : g_div
        logic [RW:0] dr_n_reg;
        always_ff @(posedge aclk) begin
            if (adv) begin
                dr_n_reg <= dr_reg[k];
                side_reg[NR+4+k] <= side_reg[NR+3+k];
            end
        end
        assign dr_reg[k+1] = dr_n_reg;
        for (genvar a = 0; a < 3; a++) begin : g_lane
            logic [RW+1:0] sh;
            logic [NW-1:0] num_n_reg, quo_n_reg;
            logic [RW+1:0] rem_n_reg;
            assign sh = {drem_reg[a][k][RW:0], num_reg[a][k][NW-1]};
            always_ff @(posedge aclk) begin
                if (adv) begin
                    num_n_reg <= {num_reg[a][k][NW-2:0], 1'b0};
                    if (sh >= {1'b0, dr_reg[k]}) begin
                        rem_n_reg <= sh - {1'b0, dr_reg[k]};
                        quo_n_reg <= {quo_reg[a][k][NW-2:0], 1'b1};
                    end else begin
                        rem_n_reg <= sh;
                        quo_n_reg <= {quo_reg[a][k][NW-2:0], 1'b0};
                    end
                end
            end
            assign num_reg[a][k+1]  = num_n_reg;
            assign drem_reg[a][k+1] = rem_n_reg;
            assign quo_reg[a][k+1]  = quo_n_reg;
        end
    end

    // Final stage: round, clamp, sign, saturate.
    localparam logic signed [plr_pkg::MIS_W+2:0] WMAX = (44'sd1 <<< 40) - 44'sd1;
    logic [RW:0] rf;
    logic signed [plr_pkg::MIS_W+2:0] wsum;
    assign rf   = dr_reg[ND];
    assign wsum = side_reg[RSTAGES-1].rest + $signed({3'd0, rf});

    function automatic logic [31:0] fin_dir(input logic [NW-1:0] q, input logic [RW+1:0] rm,
                                            input logic [RW:0] r, input logic neg);
        logic [NW-1:0] qq;
        logic [31:0] m;
        qq = q + NW'(({1'b0, rm} >= ({2'b0, r} - {1'b0, rm})));
        m  = (qq > NW'(64'd1 << 30)) ? 32'd1073741824 : qq[31:0];
        if (r == '0) fin_dir = '0;
        else fin_dir = neg ? -m : m;
    endfunction

    logic [37:0] geo_reg;
    logic [31:0] dx_reg, dy_reg, dz_reg;
    logic [40:0] mis_reg;
    logic zero_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            geo_reg <= rf[RW:38] != '0 ? '1 : rf[37:0];
            dx_reg  <= fin_dir(quo_reg[0][ND], drem_reg[0][ND], rf, side_reg[RSTAGES-1].dx[DW-1]);
            dy_reg  <= fin_dir(quo_reg[1][ND], drem_reg[1][ND], rf, side_reg[RSTAGES-1].dy[DW-1]);
            dz_reg  <= fin_dir(quo_reg[2][ND], drem_reg[2][ND], rf, side_reg[RSTAGES-1].dz[DW-1]);
            if (wsum > WMAX) mis_reg <= WMAX[40:0];
            else if (wsum < -WMAX - 44'sd1) mis_reg <= {1'b1, 40'd0};
            else mis_reg <= wsum[40:0];
            zero_reg <= (rf == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOTAL; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < TOTAL; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign m_valid      = vld_reg[TOTAL-1];
    assign m_geo_range  = geo_reg;
    assign m_dir_x      = dx_reg;
    assign m_dir_y      = dy_reg;
    assign m_dir_z      = dz_reg;
    assign m_misclosure = mis_reg;
    assign m_zero_range = zero_reg;

endmodule

>>> rtl/plr_checker.sv
// ----------------------------------------------------------------------------
// plr_checker: port-level checks on the linearization row
// Watches the handshakes and the result fields of the top level.
// ----------------------------------------------------------------------------
module plr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [37:0] m_geo_range,
    input logic [31:0] m_dir_x,
    input logic        m_zero_range
);

    // A stalled result keeps its fields.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_geo_range) && $stable(m_dir_x))
        else $error("result changed while stalled");

    // The input side is only held back by a stalled output.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // A zero range gives zero direction and zero range.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_range |-> m_geo_range == 38'd0 && m_dir_x == 32'd0)
        else $error("zero range with nonzero fields");

    // Nothing leaves the block right after reset.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pseudorange_linearization_row_top plr_checker u_plr_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .m_geo_range(m_geo_range), .m_dir_x(m_dir_x),
    .m_zero_range(m_zero_range)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pseudorange linearization row testbench
// Sends satellite observations under several station and clock settings,
// forms each expected row in the testbench and compares the returned rows
// field by field, in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic signed [36:0] sat_x;
        logic signed [36:0] sat_y;
        logic signed [36:0] sat_z;
        logic signed [30:0] sat_clk;
        logic [19:0]        trop;
        logic [35:0]        prange;
    } obs_t;

    typedef struct {
        logic [37:0]        geo;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [40:0] misc;
        logic               zero;
    } row_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 150;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [36:0] s_sat_x = '0;
    logic signed [36:0] s_sat_y = '0;
    logic signed [36:0] s_sat_z = '0;
    logic signed [30:0] s_sat_clock_bias = '0;
    logic [19:0]        s_trop_delay = '0;
    logic [35:0]        s_pseudorange = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [37:0]        m_geo_range;
    logic signed [31:0] m_dir_x;
    logic signed [31:0] m_dir_y;
    logic signed [31:0] m_dir_z;
    logic signed [40:0] m_misclosure;
    logic               m_zero_range;

    // Shadow copy of the configuration registers.
    logic signed [36:0] stn_x = '0;
    logic signed [36:0] stn_y = '0;
    logic signed [36:0] stn_z = '0;
    logic signed [36:0] rx_clk = '0;

    obs_t pending_obs[$];
    row_t expected_rows[$];
    int   error_count = 0;
    int   quiet_cycles = 0;
    bit   gaps_on = 1'b1;

    always #2 aclk = ~aclk;

    pseudorange_linearization_row_top u_dut (.*);

    function automatic logic signed [31:0] unit_coeff(logic signed [38:0] d,
                                                      logic [39:0] r);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] rem;
        logic [37:0]  a;
        begin
            a   = 38'(d < 0 ? -d : d);
            num = {58'd0, a, 30'd0};
            q   = num / 128'(r);
            rem = num % 128'(r);
            if ((rem << 1) >= 128'(r)) q = q + 128'd1;
            if (q > (128'd1 << 30)) q = 128'd1 << 30;
            return d < 0 ? -$signed(q[31:0]) : $signed(q[31:0]);
        end
    endfunction

    function automatic row_t predict_row(obs_t o);
        logic signed [38:0] dx, dy, dz, dt;
        logic [37:0]        ax, ay, az, at;
        logic [79:0]        sq_sum, cand_sq;
        logic [39:0]        rt, cand;
        logic [79:0]        clk_prod;
        logic signed [63:0] clk_term, w;
        row_t               res;
        begin
            dx = stn_x - o.sat_x;
            dy = stn_y - o.sat_y;
            dz = stn_z - o.sat_z;
            dt = rx_clk - o.sat_clk;
            ax = 38'(dx < 0 ? -dx : dx);
            ay = 38'(dy < 0 ? -dy : dy);
            az = 38'(dz < 0 ? -dz : dz);
            at = 38'(dt < 0 ? -dt : dt);
            sq_sum = 80'(ax) * ax + 80'(ay) * ay + 80'(az) * az;
            rt = '0;
            for (int b = 39; b >= 0; b--) begin
                cand    = rt | (40'd1 << b);
                cand_sq = 80'(cand) * cand;
                if (cand_sq <= sq_sum) rt = cand;
            end
            if (sq_sum > 80'(rt) * rt + rt) rt = rt + 40'd1;

            res.zero = (rt == 0);
            res.geo  = rt > 40'h3F_FFFF_FFFF ? 38'h3F_FFFF_FFFF : rt[37:0];
            if (rt != 0) begin
                res.dir_x = unit_coeff(dx, rt);
                res.dir_y = unit_coeff(dy, rt);
                res.dir_z = unit_coeff(dz, rt);
            end else begin
                res.dir_x = '0;
                res.dir_y = '0;
                res.dir_z = '0;
            end

            clk_prod = (80'(at) * 80'(plr_pkg::LIGHT_SPEED) + (80'd1 << 29)) >> 30;
            clk_term = dt < 0 ? -$signed(64'(clk_prod)) : $signed(64'(clk_prod));
            w = $signed(64'(rt)) + clk_term + $signed(64'(o.trop))
                - $signed(64'(o.prange));
            if (w > (64'sd1 << 40) - 1) w = (64'sd1 << 40) - 1;
            if (w < -(64'sd1 << 40)) w = -(64'sd1 << 40);
            res.misc = w[40:0];
            return res;
        end
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        error_count++;
    endtask

    // Input driver.
    always @(posedge aclk) begin
        obs_t o;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                o.sat_x   = s_sat_x;
                o.sat_y   = s_sat_y;
                o.sat_z   = s_sat_z;
                o.sat_clk = s_sat_clock_bias;
                o.trop    = s_trop_delay;
                o.prange  = s_pseudorange;
                expected_rows.push_back(predict_row(o));
            end
            if (!s_valid || s_ready) begin
                if (pending_obs.size() > 0 && !(gaps_on && $urandom_range(99) < 14)) begin
                    o = pending_obs.pop_front();
                    s_sat_x          <= o.sat_x;
                    s_sat_y          <= o.sat_y;
                    s_sat_z          <= o.sat_z;
                    s_sat_clock_bias <= o.sat_clk;
                    s_trop_delay     <= o.trop;
                    s_pseudorange    <= o.prange;
                    s_valid          <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and back-pressure.
    always @(posedge aclk) begin
        row_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(gaps_on && $urandom_range(99) < 14);
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch("unexpected row", 1, 0);
                end else begin
                    e = expected_rows.pop_front();
                    if (m_geo_range !== e.geo) report_mismatch("geo_range", m_geo_range, e.geo);
                    if (m_dir_x !== e.dir_x) report_mismatch("dir_x", m_dir_x, e.dir_x);
                    if (m_dir_y !== e.dir_y) report_mismatch("dir_y", m_dir_y, e.dir_y);
                    if (m_dir_z !== e.dir_z) report_mismatch("dir_z", m_dir_z, e.dir_z);
                    if (m_misclosure !== e.misc)
                        report_mismatch("misclosure", m_misclosure, e.misc);
                    if (m_zero_range !== e.zero)
                        report_mismatch("zero_range", m_zero_range, e.zero);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [4:0] addr, logic signed [36:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{27{value[36]}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_station(logic signed [36:0] x, logic signed [36:0] y,
                               logic signed [36:0] z, logic signed [36:0] c);
        write_reg(plr_pkg::ADDR_STATION_X, x);
        write_reg(plr_pkg::ADDR_STATION_Y, y);
        write_reg(plr_pkg::ADDR_STATION_Z, z);
        write_reg(plr_pkg::ADDR_RX_CLOCK, c);
        stn_x  = x;
        stn_y  = y;
        stn_z  = z;
        rx_clk = c;
    endtask

    task automatic add_obs(logic signed [36:0] x, logic signed [36:0] y,
                           logic signed [36:0] z, logic signed [30:0] c,
                           logic [19:0] t, logic [35:0] p);
        obs_t o;
        o.sat_x   = x;
        o.sat_y   = y;
        o.sat_z   = z;
        o.sat_clk = c;
        o.trop    = t;
        o.prange  = p;
        pending_obs.push_back(o);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly full-range noise, with near-station points and the odd
    // coincident point.
    task automatic add_random_obs(int count);
        logic signed [36:0] x, y, z;
        logic [63:0] r;
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            r    = rand64();
            if (kind < 5) begin
                x = stn_x;
                y = stn_y;
                z = stn_z;
            end else if (kind < 30) begin
                x = stn_x + $signed(7'($urandom));
                y = stn_y + $signed(7'($urandom));
                z = stn_z + $signed(7'($urandom));
            end else begin
                x = r[36:0];
                y = 37'(rand64());
                z = 37'(rand64());
            end
            add_obs(x, y, z, 31'($urandom), 20'($urandom),
                    kind[0] ? 36'(rand64()) : r[45:10]);
        end
    endtask

    task automatic wait_idle();
        while (pending_obs.size() != 0 || expected_rows.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    localparam logic signed [36:0] CMAX = {1'b0, {36{1'b1}}};
    localparam logic signed [36:0] CMIN = {1'b1, {36{1'b0}}};

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: station at the origin.
        add_obs('0, '0, '0, '0, '0, '0);
        add_obs('0, '0, '0, 31'sh3FFF_FFFF, 20'hFFFFF, 36'hF_FFFF_FFFF);
        add_obs(CMAX, CMAX, CMAX, {1'b1, 30'd0}, 20'hFFFFF, '0);
        add_obs(CMIN, CMIN, CMIN, 31'sh3FFF_FFFF, '0, 36'hF_FFFF_FFFF);
        add_obs(CMAX, '0, '0, '0, '0, '0);
        add_obs('0, CMIN, '0, '0, '0, '0);
        add_obs('0, '0, 37'sd1, '0, '0, '0);
        add_obs(37'sd3, 37'sd4, '0, '0, 20'd5, 36'd5);
        add_obs(-37'sd1, -37'sd1, -37'sd1, -31'sd1, 20'd1, 36'd1);
        add_random_obs(200);
        wait_idle();

        set_station(CMAX, CMAX, CMAX, CMAX);
        add_obs(CMIN, CMIN, CMIN, {1'b1, 30'd0}, 20'hFFFFF, '0);
        add_obs(CMAX, CMAX, CMAX, '0, '0, '0);
        add_random_obs(220);
        wait_idle();

        // A stretch without any gaps or stalls.
        gaps_on = 1'b0;
        set_station(CMIN, CMIN, CMIN, CMIN);
        add_obs(CMAX, CMAX, CMAX, 31'sh3FFF_FFFF, '0, 36'hF_FFFF_FFFF);
        add_obs(CMIN, CMIN, CMIN, '0, '0, '0);
        add_random_obs(220);
        wait_idle();
        gaps_on = 1'b1;

        set_station(37'(rand64()), 37'(rand64()), 37'(rand64()), 37'(rand64()));
        add_random_obs(220);
        wait_idle();

        set_station(37'sd6_000_000_000, -37'sd9_000_000_000, 37'sd4_000_000_000,
                    -37'sd1_000);
        add_random_obs(220);
        wait_idle();

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/plr_pkg.sv
rtl/pseudorange_linearization_row_top.sv
rtl/plr_checker.sv
dv/testbench.sv
